### rtl/pase_pkg.sv
// Shared widths, codes and control types for the positional array search engine.
package pase_pkg;

   localparam int DEPTH = 64;
   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int PW = 7;
   localparam int VW = 32;
   localparam int IW = 6;
   localparam int NW = 7;
   localparam int XW = ((PW > CW) ? PW : CW) + 1;

   localparam int REQ_DW = ((PW + VW + 7) / 8) * 8;
   localparam int RSP_DW = ((2 + IW + NW + 7) / 8) * 8;

   typedef enum logic [1:0] {
      MODE_INSERT = 2'd0,
      MODE_DELETE = 2'd1,
      MODE_LINEAR = 2'd2,
      MODE_BINARY = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STS_OK       = 2'd0,
      STS_BADPOS   = 2'd1,
      STS_NOTFOUND = 2'd2,
      STS_FULL     = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_SHIFT,
      S_PUT,
      S_SCAN,
      S_PROBE,
      S_JUDGE,
      S_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic init;
      logic step;
      logic probe;
      logic judge;
      logic put;
      logic cnt_inc;
      logic cnt_dec;
      logic found;
      logic miss;
      logic emit;
   } cmd_type;

   typedef struct packed {
      mode_type   mode;
      status_type pre_status;
      logic       shift_more;
      logic       scan_hit;
      logic       scan_end;
      logic       bin_empty;
      logic       bin_eq;
      logic       out_free;
   } sts_type;

endpackage

### rtl/positional_array_search_engine_unit.sv
// Top level of the positional array search engine: controller and datapath.
//
//  channel | direction | tdata (low bit up)                            | tuser
//  req_    | in        | position[6:0], value[38:7], zero pad          | mode[1:0]
//  rsp_    | out       | status[1:0], found_index[7:2], new_count[14:8] | -
//
//  One request at a time; insert shifts entries up then puts the new one, delete shifts entries down,
//  linear search steps through the entries in order, binary search probes then judges each midpoint.
//  The entry memory takes one read and one write per cycle and moves or compares one entry.
//  Reset clears the count, the controller and the result valid flag; entries stay.
//  A new request is taken while a finished result waits on a stalled rsp_tready.
module positional_array_search_engine_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [pase_pkg::REQ_DW-1:0]   req_tdata,   // position, value
   input  logic [1:0]                    req_tuser,   // mode
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [pase_pkg::RSP_DW-1:0]   rsp_tdata    // status, found_index, new_count
);
   import pase_pkg::*;

   cmd_type cmd;
   sts_type sts;

   pase_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   pase_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

### rtl/pase_ctrl.sv
// Controller state machine sequencing each request through the datapath.
module pase_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  pase_pkg::sts_type  sts,
   output pase_pkg::cmd_type  cmd
);
   import pase_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.init = 1'b1;
            if (sts.pre_status != STS_OK) begin
               state_in = S_DONE;
            end else begin
               unique case (sts.mode)
                  MODE_INSERT: state_in = S_SHIFT;
                  MODE_DELETE: state_in = S_SHIFT;
                  MODE_LINEAR: state_in = S_SCAN;
                  MODE_BINARY: state_in = S_PROBE;
                  default:     state_in = S_DONE;
               endcase
            end
         end
         S_SHIFT: begin
            if (sts.shift_more) begin
               cmd.step = 1'b1;
            end else if (sts.mode == MODE_INSERT) begin
               state_in = S_PUT;
            end else begin
               cmd.cnt_dec = 1'b1;
               state_in    = S_DONE;
            end
         end
         S_PUT: begin
            cmd.put     = 1'b1;
            cmd.cnt_inc = 1'b1;
            state_in    = S_DONE;
         end
         S_SCAN: begin
            priority if (sts.scan_hit) begin
               cmd.found = 1'b1;
               state_in  = S_DONE;
            end else if (sts.scan_end) begin
               cmd.miss = 1'b1;
               state_in = S_DONE;
            end else begin
               cmd.step = 1'b1;
            end
         end
         S_PROBE: begin
            if (sts.bin_empty) begin
               cmd.miss = 1'b1;
               state_in = S_DONE;
            end else begin
               cmd.probe = 1'b1;
               state_in  = S_JUDGE;
            end
         end
         S_JUDGE: begin
            cmd.judge = 1'b1;
            if (sts.bin_eq) begin
               cmd.found = 1'b1;
               state_in  = S_DONE;
            end else begin
               state_in = S_PROBE;
            end
         end
         S_DONE: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

### rtl/pase_dp.sv
// Datapath: entry memory, count, scan pointers, search bounds and result register.
module pase_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  pase_pkg::cmd_type             cmd,
   output pase_pkg::sts_type             sts,
   input  logic [pase_pkg::REQ_DW-1:0]   req_tdata,
   input  logic [1:0]                    req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [pase_pkg::RSP_DW-1:0]   rsp_tdata
);
   import pase_pkg::*;

   logic [VW-1:0] mem [DEPTH];

   mode_type      mode_ff;
   logic [PW-1:0] pos_ff;
   logic [VW-1:0] key_ff;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] ptr_ff;
   logic [CW-1:0] low_ff;
   logic [CW-1:0] hip_ff;
   logic [AW-1:0] mid_ff;
   logic [VW-1:0] rd_data_ff;
   logic          wr_pend_ff;
   logic [AW-1:0] wr_addr_ff;
   logic          chk_vld_ff;
   logic [AW-1:0] chk_idx_ff;
   status_type    status_ff;
   logic [AW-1:0] idx_ff;
   logic          out_full_ff;
   status_type    out_status_ff;
   logic [IW-1:0] out_idx_ff;
   logic [NW-1:0] out_count_ff;

   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [VW-1:0] wr_data;
   logic [CW:0]   mid_sum;
   logic [CW-1:0] mid;
   status_type    pre_status;
   logic          out_free;

   assign mid_sum  = {1'b0, low_ff} + {1'b0, hip_ff} - (CW+1)'(1);
   assign mid      = mid_sum[CW:1];
   assign out_free = !out_full_ff || rsp_tready;

   always_comb begin
      pre_status = STS_OK;
      unique case (mode_ff)
         MODE_INSERT: begin
            if (pos_ff == '0 || XW'(pos_ff) > XW'(count_ff) + XW'(1)) begin
               pre_status = STS_BADPOS;
            end else if (count_ff == CW'(DEPTH)) begin
               pre_status = STS_FULL;
            end
         end
         MODE_DELETE: begin
            if (pos_ff == '0 || XW'(pos_ff) > XW'(count_ff)) begin
               pre_status = STS_BADPOS;
            end
         end
         default: pre_status = STS_OK;
      endcase
   end

   always_comb begin
      rd_addr = ptr_ff[AW-1:0];
      if (cmd.probe) begin
         rd_addr = AW'(mid);
      end else if (cmd.step) begin
         unique case (mode_ff)
            MODE_INSERT: rd_addr = AW'(ptr_ff - CW'(1));
            MODE_DELETE: rd_addr = AW'(ptr_ff + CW'(1));
            default:     rd_addr = ptr_ff[AW-1:0];
         endcase
      end
   end

   always_comb begin
      wr_en   = wr_pend_ff || cmd.put;
      wr_addr = cmd.put ? AW'(pos_ff - PW'(1)) : wr_addr_ff;
      wr_data = cmd.put ? key_ff : rd_data_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      sts.mode       = mode_ff;
      sts.pre_status = pre_status;
      sts.shift_more = (mode_ff == MODE_INSERT) ? (XW'(ptr_ff) >= XW'(pos_ff))
                                                : (XW'(ptr_ff) + XW'(1) < XW'(count_ff));
      sts.scan_hit   = chk_vld_ff && (rd_data_ff == key_ff);
      sts.scan_end   = (ptr_ff >= count_ff) && !chk_vld_ff;
      sts.bin_empty  = low_ff >= hip_ff;
      sts.bin_eq     = rd_data_ff == key_ff;
      sts.out_free   = out_free;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= mode_type'(req_tuser);
         pos_ff  <= req_tdata[PW-1:0];
         key_ff  <= req_tdata[PW+VW-1:PW];
      end
      if (cmd.init) begin
         status_ff <= pre_status;
         idx_ff    <= '0;
         low_ff    <= '0;
         hip_ff    <= count_ff;
         unique case (mode_ff)
            MODE_INSERT: ptr_ff <= count_ff;
            MODE_DELETE: ptr_ff <= CW'(pos_ff - PW'(1));
            default:     ptr_ff <= '0;
         endcase
      end else if (cmd.step) begin
         wr_addr_ff <= ptr_ff[AW-1:0];
         chk_idx_ff <= ptr_ff[AW-1:0];
         unique case (mode_ff)
            MODE_INSERT: ptr_ff <= ptr_ff - CW'(1);
            MODE_DELETE: ptr_ff <= ptr_ff + CW'(1);
            default: begin
               if (ptr_ff < count_ff) begin
                  ptr_ff <= ptr_ff + CW'(1);
               end
            end
         endcase
      end
      if (cmd.probe) begin
         mid_ff <= AW'(mid);
      end
      if (cmd.judge && !sts.bin_eq) begin
         if ($signed(rd_data_ff) < $signed(key_ff)) begin
            low_ff <= CW'(mid_ff) + CW'(1);
         end else begin
            hip_ff <= CW'(mid_ff);
         end
      end
      if (cmd.found) begin
         status_ff <= STS_OK;
         idx_ff    <= (mode_ff == MODE_BINARY) ? mid_ff : chk_idx_ff;
      end else if (cmd.miss) begin
         status_ff <= STS_NOTFOUND;
         idx_ff    <= '0;
      end
      if (cmd.emit) begin
         out_status_ff <= status_ff;
         out_idx_ff    <= IW'(idx_ff);
         out_count_ff  <= NW'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         wr_pend_ff  <= 1'b0;
         chk_vld_ff  <= 1'b0;
         out_full_ff <= 1'b0;
      end else begin
         wr_pend_ff <= cmd.step && (mode_ff == MODE_INSERT || mode_ff == MODE_DELETE);
         chk_vld_ff <= cmd.step && (mode_ff == MODE_LINEAR) && (ptr_ff < count_ff);
         if (cmd.cnt_inc) begin
            count_ff <= count_ff + CW'(1);
         end else if (cmd.cnt_dec) begin
            count_ff <= count_ff - CW'(1);
         end
         if (cmd.emit) begin
            out_full_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_full_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = out_full_ff;
   assign rsp_tdata  = RSP_DW'({out_count_ff, out_idx_ff, out_status_ff});

   a_one_write: assert property (@(posedge clock) disable iff (reset)
      !(wr_pend_ff && cmd.put))
      else $error("shift write and insert write collide");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count above depth");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      (!cmd.cnt_inc && !cmd.cnt_dec) |=> $stable(count_ff))
      else $error("entry count changed without command");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> out_free)
      else $error("result register overwritten");

endmodule
